@@ rtl/tbc_pkg.sv @@
// Shared types, constants and round functions for the 32-bit toy block cipher.
package tbc_pkg;

	localparam int BLOCK_W     = 32;
	localparam int NUM_KEYS    = 8;
	localparam int KEY_IDX_W   = 3;
	localparam int ROUNDS_DEF  = 4;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	localparam logic [7:0] SLICE_3 = 8'hC0;
	localparam logic [7:0] SLICE_2 = 8'h30;
	localparam logic [7:0] SLICE_1 = 8'h0C;
	localparam logic [7:0] SLICE_0 = 8'h03;

	localparam logic [7:0] MUL_ENC = 8'd27;
	localparam logic [7:0] MUL_DEC = 8'd19;

	// One block in flight; byte i of data is v[i] (byte a at bits 7:0).
	typedef struct packed {
		logic               valid;
		logic               mode;
		logic [BLOCK_W-1:0] data;
	} tbc_beat_t;

	function automatic logic [7:0] mul_byte(input logic [7:0] x, input logic [7:0] m);
		logic [15:0] p;
		p = 16'(x) * 16'(m);
		return p[7:0];
	endfunction

	function automatic logic [BLOCK_W-1:0] byte_swap(input logic [BLOCK_W-1:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	function automatic logic [BLOCK_W-1:0] enc_round(input logic [BLOCK_W-1:0] w,
	                                                  input logic [BLOCK_W-1:0] k);
		logic [BLOCK_W-1:0] x;
		logic [7:0] e, f, g, h, m0, m1, m2, m3;
		x  = w ^ k;
		e  = x[7:0];
		f  = x[15:8];
		g  = x[23:16];
		h  = x[31:24];
		m0 = (e & SLICE_3) | (f & SLICE_2) | (g & SLICE_1) | (h & SLICE_0);
		m1 = (f & SLICE_3) | (g & SLICE_2) | (h & SLICE_1) | (e & SLICE_0);
		m2 = (g & SLICE_3) | (h & SLICE_2) | (e & SLICE_1) | (f & SLICE_0);
		m3 = (h & SLICE_3) | (e & SLICE_2) | (f & SLICE_1) | (g & SLICE_0);
		return {mul_byte(m3, MUL_ENC), mul_byte(m2, MUL_ENC),
		        mul_byte(m1, MUL_ENC), mul_byte(m0, MUL_ENC)};
	endfunction

	function automatic logic [BLOCK_W-1:0] dec_round(input logic [BLOCK_W-1:0] w,
	                                                  input logic [BLOCK_W-1:0] k);
		logic [7:0] e, f, g, h, m0, m1, m2, m3;
		e  = mul_byte(w[7:0],   MUL_DEC);
		f  = mul_byte(w[15:8],  MUL_DEC);
		g  = mul_byte(w[23:16], MUL_DEC);
		h  = mul_byte(w[31:24], MUL_DEC);
		m0 = (e & SLICE_3) | (h & SLICE_2) | (g & SLICE_1) | (f & SLICE_0);
		m1 = (f & SLICE_3) | (e & SLICE_2) | (h & SLICE_1) | (g & SLICE_0);
		m2 = (g & SLICE_3) | (f & SLICE_2) | (e & SLICE_1) | (h & SLICE_0);
		m3 = (h & SLICE_3) | (g & SLICE_2) | (f & SLICE_1) | (e & SLICE_0);
		return {m3, m2, m1, m0} ^ k;
	endfunction

endpackage

@@ rtl/toy_block_cipher_32bit.sv @@
// Top level of the 32-bit toy block cipher: key registers and a chain of round cells.
// A block taken with start is registered in each round cell in turn and is on done once it leaves the last cell.
// Throughput: one block per cycle; busy stays low, one round cell per round.
// Each cell holds one block and hands it to the next cell every cycle.
// Reset (arst_n low) clears all round keys to zero and drops every beat in the chain.
// Results come out on done for one cycle; the receiver cannot stall them.
module toy_block_cipher_32bit
	import tbc_pkg::*;
#(
	parameter int ROUNDS = ROUNDS_DEF
)(
	input  logic                 clk,
	input  logic                 arst_n,
	// command side
	input  logic                 start,
	output logic                 busy,
	input  logic                 mode,
	input  logic [BLOCK_W-1:0]   block_in,
	// result side
	output logic                 done,
	output logic [BLOCK_W-1:0]   block_out,
	// key write port
	input  logic                 wr_en,
	input  logic [KEY_IDX_W-1:0] wr_index,
	input  logic [BLOCK_W-1:0]   wr_data
);

	// Round key file. Each cell reads fixed entries, so these stay flops.
	logic [BLOCK_W-1:0] keys_q [NUM_KEYS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				keys_q[i] <= '0;
			end
		end else if (wr_en) begin
			keys_q[wr_index] <= wr_data;
		end
	end

	// The chain never backs up, so a new beat is taken every cycle.
	assign busy = 1'b0;

	// chain[0] is the incoming beat; chain[k+1] is the output of cell k.
	tbc_beat_t chain [ROUNDS+1];

	// Internal byte order has byte a in bits 7:0. Encrypt input carries a
	// in bits 31:24, so it is byte swapped; decrypt input is already in place.
	assign chain[0] = '{valid: start & ~busy,
	                    mode:  mode,
	                    data:  (mode == MODE_DEC) ? block_in : byte_swap(block_in)};

	// Cell k runs round k when encrypting and round ROUNDS-1-k when decrypting,
	// so the same chain serves both directions.
	for (genvar k = 0; k < ROUNDS; k++) begin : g_cell
		tbc_round_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.prev    (chain[k]),
			.key_enc (keys_q[KEY_IDX_W'(k)]),
			.key_dec (keys_q[KEY_IDX_W'(ROUNDS - 1 - k)]),
			.next    (chain[k+1])
		);
	end

	// Output: encrypt leaves a in bits 7:0, decrypt puts a in bits 31:24.
	assign done      = chain[ROUNDS].valid;
	assign block_out = (chain[ROUNDS].mode == MODE_DEC) ? byte_swap(chain[ROUNDS].data)
	                                                    : chain[ROUNDS].data;

	// A result beat only appears once an accepted command has passed through every round cell.
	a_done_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, ROUNDS))
		else $error("done without a command ROUNDS cycles earlier");

	a_no_cmd_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start, ROUNDS) |-> !done)
		else $error("done strobe with no matching command");

	a_mode_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (chain[ROUNDS].mode == $past(mode, ROUNDS)))
		else $error("mode of result beat does not match its command");

endmodule

@@ rtl/tbc_round_cell.sv @@
// One round cell: applies an encrypt or decrypt round and registers the beat.
module tbc_round_cell
	import tbc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  tbc_beat_t          prev,
	input  logic [BLOCK_W-1:0] key_enc,
	input  logic [BLOCK_W-1:0] key_dec,
	output tbc_beat_t          next
);

	logic               valid_q;
	logic               mode_q;
	logic [BLOCK_W-1:0] data_q;
	logic [BLOCK_W-1:0] round_out;

	always_comb begin
		if (prev.mode == MODE_DEC) begin
			round_out = dec_round(prev.data, key_dec);
		end else begin
			round_out = enc_round(prev.data, key_enc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		mode_q <= prev.mode;
		data_q <= round_out;
	end

	assign next = '{valid: valid_q, mode: mode_q, data: data_q};

endmodule
